### hw/rtl/hbcd_pkg.sv
// Shared types and constants for the chunked HTTP body deframer.
package hbcd_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int unsigned LengthBitsDef   = 40;
  localparam int unsigned MaxLineBytesDef = 128;

  // Fixed field widths.
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenRegW    = 41;
  localparam int unsigned LineW      = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdxMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxLength = 2'd1;

  // Line control characters.
  localparam logic [ByteW-1:0] ChLf = 8'h0A;
  localparam logic [ByteW-1:0] ChCr = 8'h0D;

  typedef enum logic [1:0] {
    ModeNone    = 2'd0,
    ModeLength  = 2'd1,
    ModeClose   = 2'd2,
    ModeChunked = 2'd3
  } body_mode_e;

  typedef enum logic [2:0] {
    PhSize  = 3'd0,
    PhEnd   = 3'd1,
    PhData  = 3'd2,
    PhTrail = 3'd3,
    PhDone  = 3'd4
  } phase_e;

  // One classified input request, as it travels from the front to the engine.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             closed;
    logic             is_lf;
    logic             is_cr;
    logic             is_hex;
    logic [3:0]       hex_val;
  } byte_class_t;

  // One result request, as it travels from the engine to the result queue.
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    logic             body_done;
    logic             status_code;
  } result_t;

endpackage

### hw/rtl/hbcd_fifo.sv
// Small register-based first-in first-out queue.
module hbcd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o    = (count_q == CntFull);
  assign empty_o   = (count_q == '0);
  assign wr_en     = wr_valid_i && !full_o;
  assign rd_en     = rd_ready_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({wr_en, rd_en})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage holds payload only, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/hbcd_front.sv
// Front end: accepts raw bytes, classifies them and queues them for the engine.
module hbcd_front
  import hbcd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             conn_closed_i,
  output logic             cls_valid_o,
  output byte_class_t      cls_o,
  input  logic             cls_ready_i
);

  localparam logic [ByteW-1:0] ChZero = 8'h30;
  localparam logic [ByteW-1:0] ChNine = 8'h39;
  localparam logic [ByteW-1:0] ChLowA = 8'h61;
  localparam logic [ByteW-1:0] ChLowF = 8'h66;
  localparam logic [ByteW-1:0] ChUpA  = 8'h41;
  localparam logic [ByteW-1:0] ChUpF  = 8'h46;

  byte_class_t cls;
  logic        queue_empty;

  // Decode line breaks and hex digits once, so the engine only selects.
  always_comb begin
    cls         = '0;
    cls.data    = data_byte_i;
    cls.closed  = conn_closed_i;
    cls.is_lf   = (data_byte_i == ChLf);
    cls.is_cr   = (data_byte_i == ChCr);
    priority if (data_byte_i >= ChZero && data_byte_i <= ChNine) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(data_byte_i - ChZero);
    end else if (data_byte_i >= ChLowA && data_byte_i <= ChLowF) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(data_byte_i - ChLowA) + 4'd10;
    end else if (data_byte_i >= ChUpA && data_byte_i <= ChUpF) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(data_byte_i - ChUpA) + 4'd10;
    end else begin
      cls.is_hex  = 1'b0;
      cls.hex_val = 4'd0;
    end
  end

  // Queue between the front and the engine.
  hbcd_fifo #(
    .Width ($bits(byte_class_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_data_i  (cls),
    .full_o     (full),
    .rd_ready_i (cls_ready_i),
    .rd_data_o  (cls_o),
    .empty_o    (queue_empty)
  );

  assign cls_valid_o = !queue_empty;

endmodule

### hw/rtl/hbcd_engine.sv
// Back end: framing state machine that turns each classified byte into one result.
module hbcd_engine
  import hbcd_pkg::*;
#(
  parameter int unsigned LengthBits   = LengthBitsDef,
  parameter int unsigned MaxLineBytes = MaxLineBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LenRegW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  byte_class_t        in_cls_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output result_t            out_res_o,
  input  logic               out_full_i
);

  // The counter holds either a content length or a chunk size.
  localparam int unsigned CntW = (LengthBits > LenRegW - 1) ? LengthBits : LenRegW - 1;
  localparam logic [CntW-1:0]  SizeMax = CntW'((65'd1 << LengthBits) - 65'd1);
  localparam logic [CntW-1:0]  CntOne  = CntW'(1);
  localparam logic [LineW-1:0] LineMax = LineW'(MaxLineBytes);
  localparam logic [LineW-1:0] LineSat = '1;
  localparam logic [LineW-1:0] LineOne = LineW'(1);

  body_mode_e         mode_q, mode_d;
  logic [LenRegW-1:0] len_q, len_d;
  phase_e             phase_q, phase_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               unlimited_q, unlimited_d;
  logic [LineW-1:0]   line_q, line_d;
  logic               stopped_q, stopped_d;
  logic               first_cr_q, first_cr_d;
  logic               finished_q, finished_d;

  logic               step;
  logic               restart;
  logic               length_mode;
  logic               trail_empty;
  logic               size_sat;
  logic               line_over;
  logic [LineW-1:0]   line_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_full_i;
  assign step        = in_valid_i && !out_full_i;
  assign out_valid_o = step;

  assign restart     = cfg_valid_i &&
                       (cfg_index_i == CfgIdxMode || cfg_index_i == CfgIdxLength);
  assign length_mode = (mode_q == ModeLength) || (mode_q == ModeClose);
  assign trail_empty = (line_q == '0) || (line_q == LineOne && first_cr_q);
  assign size_sat    = (cnt_q[CntW-1:LengthBits-4] != '0);
  assign line_inc    = (line_q != LineSat) ? line_q + 1'b1 : line_q;
  assign line_over   = (phase_q != PhTrail) && (line_inc >= LineMax);

  // New register values take effect from the write, and restart the body.
  always_comb begin
    mode_d = mode_q;
    len_d  = len_q;
    if (cfg_valid_i && cfg_index_i == CfgIdxMode) begin
      mode_d = body_mode_e'(cfg_data_i[1:0]);
    end
    if (cfg_valid_i && cfg_index_i == CfgIdxLength) begin
      len_d = cfg_data_i;
    end
  end

  // Next state of the framing machine.
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    unlimited_d = unlimited_q;
    line_d      = line_q;
    stopped_d   = stopped_q;
    first_cr_d  = first_cr_q;
    finished_d  = finished_q;
    if (restart) begin
      phase_d     = PhSize;
      unlimited_d = len_d[LenRegW-1];
      cnt_d       = (mode_d == ModeChunked || len_d[LenRegW-1]) ? '0 :
                    CntW'(len_d[LenRegW-2:0]);
      line_d      = '0;
      stopped_d   = 1'b0;
      first_cr_d  = 1'b0;
      finished_d  = (mode_d == ModeNone) ||
                    ((mode_d == ModeLength || mode_d == ModeClose) && len_d == '0);
    end else if (step) begin
      priority if (finished_q || in_cls_i.closed) begin
        finished_d = 1'b1;
      end else if (length_mode) begin
        if (!unlimited_q && cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CntOne) begin
            finished_d = 1'b1;
          end
        end
      end else if (phase_q == PhData) begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q <= CntOne) begin
          cnt_d   = '0;
          phase_d = PhEnd;
        end
      end else if (in_cls_i.is_lf) begin
        unique case (phase_q)
          PhSize: begin
            phase_d = (cnt_q != '0) ? PhData : PhTrail;
          end
          PhEnd: begin
            phase_d   = PhSize;
            cnt_d     = '0;
            stopped_d = 1'b0;
          end
          PhTrail: begin
            if (trail_empty) begin
              phase_d    = PhDone;
              finished_d = 1'b1;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
        line_d     = '0;
        first_cr_d = 1'b0;
      end else begin
        if (line_q == '0) begin
          first_cr_d = in_cls_i.is_cr;
        end
        // Hex size digits accumulate until the first other character.
        if (phase_q == PhSize && !stopped_q) begin
          if (!in_cls_i.is_hex) begin
            stopped_d = 1'b1;
          end else if (size_sat) begin
            cnt_d = SizeMax;
          end else begin
            cnt_d = {cnt_q[CntW-5:0], in_cls_i.hex_val};
          end
        end
        line_d = line_inc;
        if (line_over) begin
          finished_d = 1'b1;
        end
      end
    end
  end

  // Result for the byte at the head of the queue.
  always_comb begin
    out_res_o = '0;
    priority if (finished_q) begin
      out_res_o.body_done = 1'b1;
    end else if (in_cls_i.closed) begin
      out_res_o.body_done   = 1'b1;
      out_res_o.status_code = (mode_q == ModeLength) ||
                              (mode_q == ModeChunked &&
                               (phase_q == PhData || line_q != '0));
    end else if (length_mode) begin
      out_res_o.payload_byte  = in_cls_i.data;
      out_res_o.payload_valid = 1'b1;
      out_res_o.body_done     = !unlimited_q && cnt_q == CntOne;
    end else if (phase_q == PhData) begin
      out_res_o.payload_byte  = in_cls_i.data;
      out_res_o.payload_valid = 1'b1;
    end else if (in_cls_i.is_lf) begin
      out_res_o.body_done = (phase_q == PhTrail) && trail_empty;
    end else begin
      out_res_o.body_done   = line_over;
      out_res_o.status_code = line_over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeNone;
      len_q       <= '1;
      phase_q     <= PhSize;
      cnt_q       <= '0;
      unlimited_q <= 1'b1;
      line_q      <= '0;
      stopped_q   <= 1'b0;
      first_cr_q  <= 1'b0;
      finished_q  <= 1'b1;
    end else begin
      mode_q      <= mode_d;
      len_q       <= len_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      unlimited_q <= unlimited_d;
      line_q      <= line_d;
      stopped_q   <= stopped_d;
      first_cr_q  <= first_cr_d;
      finished_q  <= finished_d;
    end
  end

endmodule

### hw/rtl/http_body_chunked_deframer.sv
// Block top: HTTP body deframer with byte queue, framing engine and result queue.
//
// Takes one body byte (or a connection-closed marker) per request and returns
// exactly one result per request: the byte if it is payload, a done flag and an
// error status. Body framing follows body_mode (none, content length, until
// close, chunked). The block sustains one request per clock cycle while results
// are popped. A request waits in the input queue; the framing engine, a
// combinational state update that sets the rate, writes its result straight
// into the result queue at the next edge unless that queue is full; the result
// ports show the head of that queue. Both queues hold two entries, so short
// stalls are absorbed; a longer receiver stall fills both queues and holds off
// the sender. There is no clearing pass after reset. Configuration writes
// restart the body and must only be issued while no request is outstanding.
module http_body_chunked_deframer
  import hbcd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS    = LengthBitsDef,
  parameter int unsigned MAX_LINE_BYTES = MaxLineBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               conn_closed_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LenRegW-1:0] cfg_data_i,
  input  logic               pop,
  output logic               empty,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic               payload_valid_o,
  output logic               body_done_o,
  output logic               status_code_o
);

  byte_class_t cls;
  logic        cls_valid;
  logic        cls_ready;
  result_t     res;
  logic        res_valid;
  logic        res_full;
  result_t     head;

  // Front end with its queue.
  hbcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .conn_closed_i (conn_closed_i),
    .cls_valid_o   (cls_valid),
    .cls_o         (cls),
    .cls_ready_i   (cls_ready)
  );

  // Framing engine.
  hbcd_engine #(
    .LengthBits   (LENGTH_BITS),
    .MaxLineBytes (MAX_LINE_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (cls_valid),
    .in_cls_i    (cls),
    .in_ready_o  (cls_ready),
    .out_valid_o (res_valid),
    .out_res_o   (res),
    .out_full_i  (res_full)
  );

  // Result queue.
  hbcd_fifo #(
    .Width ($bits(result_t)),
    .Depth (QueueDepth)
  ) u_result_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_data_i  (res),
    .full_o     (res_full),
    .rd_ready_i (pop),
    .rd_data_o  (head),
    .empty_o    (empty)
  );

  assign payload_byte_o  = head.payload_byte;
  assign payload_valid_o = head.payload_valid;
  assign body_done_o     = head.body_done;
  assign status_code_o   = head.status_code;

endmodule

### hw/rtl/hbcd_checker.sv
// Port-level checks for the deframer, attached to the top level by bind.
module hbcd_checker
  import hbcd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             pop,
  input logic             empty,
  input logic [ByteW-1:0] payload_byte_o,
  input logic             payload_valid_o,
  input logic             body_done_o,
  input logic             status_code_o
);

  // An error status only ever comes with the end of the body.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_code_o) |-> body_done_o)
    else $error("status set without body done");

  // A byte that ends the body in error is never payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_code_o) |-> !payload_valid_o)
    else $error("payload flagged on an error result");

  // Non-payload results carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !payload_valid_o) |-> (payload_byte_o == '0))
    else $error("non-payload result with nonzero byte");

  // A waiting result stays until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(payload_byte_o) && $stable(body_done_o)))
    else $error("waiting result changed or vanished");

endmodule

bind http_body_chunked_deframer hbcd_checker u_hbcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pop             (pop),
  .empty           (empty),
  .payload_byte_o  (payload_byte_o),
  .payload_valid_o (payload_valid_o),
  .body_done_o     (body_done_o),
  .status_code_o   (status_code_o)
);

### tb/tb_http_body_chunked_deframer.sv
// Self-checking testbench for the HTTP body deframer: stimulus, prediction and result checks.
module tb_http_body_chunked_deframer;
  import hbcd_pkg::*;

  localparam int CycleLimit = 500000;
  localparam logic [LenRegW-1:0] LenUnlimited = {LenRegW{1'b1}};
  localparam logic [LenRegW-1:0] LenMax = 41'd1099511627775;
  localparam logic [LenRegW-1:0] LenMostNeg = 41'h100_0000_0000;

  // One raw request toward the block: a byte, or the connection-closed marker.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             closed;
  } conn_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [ByteW-1:0] data_byte_i = '0;
  logic conn_closed_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [LenRegW-1:0] cfg_data_i = '0;
  logic pop = 1'b0;
  logic empty;
  logic [ByteW-1:0] payload_byte_o;
  logic payload_valid_o;
  logic body_done_o;
  logic status_code_o;

  http_body_chunked_deframer #(
    .LENGTH_BITS   (LengthBitsDef),
    .MAX_LINE_BYTES(MaxLineBytesDef)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .conn_closed_i  (conn_closed_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pop            (pop),
    .empty          (empty),
    .payload_byte_o (payload_byte_o),
    .payload_valid_o(payload_valid_o),
    .body_done_o    (body_done_o),
    .status_code_o  (status_code_o)
  );

  // Requests still to be offered, and deframer results still to be seen.
  conn_item_t conn_q[$];
  result_t    deframed_q[$];

  // Pacing of both sides and the long receiver hold-off.
  int  in_gap_max = 0;
  int  out_gap_max = 0;
  int  in_wait = 0;
  int  out_wait = 0;
  bit  offer;
  bit  in_fire_q = 1'b0;
  bit  out_fire_q = 1'b0;
  bit  stall_arm = 1'b0;
  bit  stall_on = 1'b0;

  // Bookkeeping.
  int  n_sent = 0;
  int  n_tail = 0;
  int  n_out = 0;
  int  n_err = 0;
  int  n_held = 0;
  int  n_cfg = 0;
  int  n_bodies = 0;
  int  n_chunked = 0;
  int  cycle_cnt = 0;
  result_t want;

  // Predictor copy of the registers and of the framing state.
  body_mode_e                pmode;
  logic signed [LenRegW-1:0] plen;
  phase_e                    ph;
  longint                    left;
  int unsigned               line_len;
  bit                        size_stop;
  bit                        first_cr;
  bit                        over;

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Reset is held low after start and released on a falling edge.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // A register write starts the body over with the current settings.
  function automatic void restart_body();
    ph        = PhSize;
    left      = (pmode == ModeChunked) ? 64'sd0 : longint'(plen);
    line_len  = 0;
    size_stop = 1'b0;
    first_cr  = 1'b0;
    over      = (pmode == ModeNone) ||
                ((pmode == ModeLength || pmode == ModeClose) && plen == 0);
  endfunction

  // Works out the result of one request and advances the framing state.
  function automatic result_t deframe_byte(logic [ByteW-1:0] b, logic closed);
    result_t r;
    longint unsigned acc;
    longint unsigned maxv;
    int d;
    r    = '0;
    maxv = (64'd1 << LengthBitsDef) - 1;
    if (over || ph == PhDone) begin
      over = 1'b1;
      r.body_done = 1'b1;
    end else if (closed) begin
      over = 1'b1;
      r.body_done = 1'b1;
      if (pmode == ModeLength) begin
        r.status_code = 1'b1;
      end else if (pmode == ModeChunked) begin
        r.status_code = (ph == PhData || line_len != 0);
      end
    end else if (pmode == ModeLength || pmode == ModeClose) begin
      r.payload_byte  = b;
      r.payload_valid = 1'b1;
      if (left > 0) begin
        left--;
        if (left == 0) begin
          over = 1'b1;
          r.body_done = 1'b1;
        end
      end
    end else if (ph == PhData) begin
      r.payload_byte  = b;
      r.payload_valid = 1'b1;
      left--;
      if (left <= 0) begin
        left = 0;
        ph   = PhEnd;
      end
    end else if (b == ChLf) begin
      if (ph == PhSize) begin
        ph = (left > 0) ? PhData : PhTrail;
      end else if (ph == PhEnd) begin
        ph        = PhSize;
        left      = 0;
        size_stop = 1'b0;
      end else if (line_len == 0 || (line_len == 1 && first_cr)) begin
        ph   = PhDone;
        over = 1'b1;
        r.body_done = 1'b1;
      end
      line_len = 0;
      first_cr = 1'b0;
    end else begin
      if (line_len == 0) first_cr = (b == ChCr);
      if (ph == PhSize && !size_stop) begin
        if (b >= "0" && b <= "9") d = b - "0";
        else if (b >= "a" && b <= "f") d = b - "a" + 10;
        else if (b >= "A" && b <= "F") d = b - "A" + 10;
        else d = -1;
        if (d < 0) begin
          size_stop = 1'b1;
        end else begin
          acc = longint'(left);
          if (acc > ((maxv - longint'(d)) >> 4)) acc = maxv;
          else acc = acc * 16 + longint'(d);
          left = longint'(acc);
        end
      end
      if (line_len < 255) line_len++;
      if (ph != PhTrail && line_len >= MaxLineBytesDef) begin
        over = 1'b1;
        r.body_done   = 1'b1;
        r.status_code = 1'b1;
      end
    end
    return r;
  endfunction

  // Counts a mismatch and prints one line about each of the first 200.
  task automatic flag_error(string what);
    n_err++;
    if (n_err <= 200) $display("MISMATCH at cycle %0d: %s", cycle_cnt, what);
  endtask

  // Sender: offers the next request after a drawn number of idle cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      offer = push && !in_fire_q;
      if (in_fire_q) in_wait = $urandom_range(0, in_gap_max);
      if (!offer) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (conn_q.size() > 0) begin
          data_byte_i   <= conn_q[0].data;
          conn_closed_i <= conn_q[0].closed;
          void'(conn_q.pop_front());
          offer = 1'b1;
        end
      end
      push <= offer;
    end
  end

  // Receiver: pops results, idling a drawn number of cycles after each one.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (out_fire_q) out_wait = $urandom_range(0, out_gap_max);
      if (stall_on) begin
        pop <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering requests.
  initial begin
    while (!(stall_arm && conn_q.size() > 40)) @(negedge clk_i);
    stall_on <= 1'b1;
    repeat (300) @(negedge clk_i);
    stall_on <= 1'b0;
  end

  // Monitor: predicts each accepted request and checks each accepted result.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire_q  <= 1'b0;
      out_fire_q <= 1'b0;
    end else begin
      in_fire_q  <= push && !full;
      out_fire_q <= pop && !empty;
      if (push && full) n_held++;
      if (push && !full) deframed_q.push_back(deframe_byte(data_byte_i, conn_closed_i));
      if (pop && !empty) begin
        n_out++;
        if (deframed_q.size() == 0) begin
          flag_error("result arrived with nothing outstanding");
        end else begin
          want = deframed_q.pop_front();
          if (payload_byte_o !== want.payload_byte)
            flag_error($sformatf("payload_byte got %h want %h",
                                 payload_byte_o, want.payload_byte));
          if (payload_valid_o !== want.payload_valid)
            flag_error($sformatf("payload_valid got %b want %b",
                                 payload_valid_o, want.payload_valid));
          if (body_done_o !== want.body_done)
            flag_error($sformatf("body_done got %b want %b",
                                 body_done_o, want.body_done));
          if (status_code_o !== want.status_code)
            flag_error($sformatf("status_code got %b want %b",
                                 status_code_o, want.status_code));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_cnt, n_sent - n_out);
      $display("tb_http_body_chunked_deframer: done, errors");
      $finish;
    end
  end

  // Stimulus helpers.
  task automatic queue_item(logic [ByteW-1:0] b, logic closed);
    conn_q.push_back('{data: b, closed: closed});
    n_sent++;
  endtask

  task automatic queue_close();
    queue_item(ByteW'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item(s[i], 1'b0);
  endtask

  task automatic queue_eol();
    if ($urandom_range(0, 1)) queue_item(ChCr, 1'b0);
    queue_item(ChLf, 1'b0);
  endtask

  function automatic logic [ByteW-1:0] text_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 255));
    if (b == ChLf) b = "x";
    return b;
  endfunction

  // Requests after the end of the body, which the block only acknowledges.
  task automatic queue_tail();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) queue_close();
      else queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
      n_tail++;
    end
  endtask

  // Size line: hex digits in either case, optional leading zeros and extension.
  task automatic queue_size_line(int sz);
    string s;
    s = $sformatf("%0h", sz);
    if ($urandom_range(0, 1)) s = s.toupper();
    repeat ($urandom_range(0, 2)) s = {"0", s};
    queue_text(s);
    if ($urandom_range(0, 3) == 0) begin
      queue_item(";", 1'b0);
      repeat ($urandom_range(0, 6)) queue_item(text_byte(), 1'b0);
    end
    queue_eol();
  endtask

  // A complete chunked body with random sizes, content and trailers.
  task automatic queue_chunked_body();
    int n_chunks;
    int sz;
    int n;
    logic [ByteW-1:0] b;
    n_chunks = $urandom_range(0, 3);
    for (int k = 0; k <= n_chunks; k++) begin
      sz = (k == n_chunks) ? 0 : $urandom_range(1, 24);
      queue_size_line(sz);
      if (sz > 0) begin
        repeat (sz) queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) queue_item(text_byte(), 1'b0);
        queue_eol();
      end
    end
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 23))
        0:       n = 260;
        1, 2:    n = 140;
        default: n = $urandom_range(1, 12);
      endcase
      b = text_byte();
      if (b == ChCr) b = "t";
      queue_item(b, 1'b0);
      repeat (n - 1) queue_item(text_byte(), 1'b0);
      queue_eol();
    end
    queue_eol();
  endtask

  // Waits until every request has produced its result.
  task automatic drain();
    while (n_out < n_sent) @(negedge clk_i);
  endtask

  // Register write, applied to the predictor when the block takes it.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LenRegW-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgIdxMode) pmode = body_mode_e'(val[1:0]);
    else plen = val;
    restart_body();
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Starts a new body: drain, choose the pacing, write both registers.
  task automatic start_body(body_mode_e m, logic [LenRegW-1:0] len);
    drain();
    case ($urandom_range(0, 3))
      0: begin in_gap_max = 0;  out_gap_max = 0;  end
      1: begin in_gap_max = 13; out_gap_max = 0;  end
      2: begin in_gap_max = 0;  out_gap_max = 13; end
      default: begin in_gap_max = 13; out_gap_max = 13; end
    endcase
    if ($urandom_range(0, 1)) begin
      write_reg(CfgIdxLength, len);
      write_reg(CfgIdxMode, LenRegW'(m));
    end else begin
      write_reg(CfgIdxMode, LenRegW'(m));
      write_reg(CfgIdxLength, len);
    end
    n_bodies++;
    if (m == ModeChunked) n_chunked++;
  endtask

  // Main sequence.
  initial begin
    logic [LenRegW-1:0] len;
    int plain_len;
    int s0;
    int cut;
    int n;
    string digits;

    pmode = ModeNone;
    plen  = LenUnlimited;
    restart_body();
    while (!rst_ni) @(negedge clk_i);

    // Directed: no body after reset, extremes of the byte.
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    // Content length cut short by a close.
    start_body(ModeLength, 41'd3);
    queue_item(8'h55, 1'b0);
    queue_item(8'hAA, 1'b0);
    queue_close();
    // Zero length ends at once.
    start_body(ModeLength, '0);
    queue_item(8'h12, 1'b0);
    // Until close, unlimited.
    start_body(ModeClose, LenUnlimited);
    queue_item("A", 1'b0);
    queue_close();
    // Chunked: one chunk with an extension, last chunk, empty trailer.
    start_body(ModeChunked, LenMax);
    queue_text("1;x");
    queue_item(ChCr, 1'b0);
    queue_item(ChLf, 1'b0);
    queue_item("Z", 1'b0);
    queue_item(ChCr, 1'b0);
    queue_item(ChLf, 1'b0);
    queue_item("0", 1'b0);
    queue_item(ChLf, 1'b0);
    queue_item(ChCr, 1'b0);
    queue_item(ChLf, 1'b0);
    // Chunked: close inside the size line, then close at a line start.
    start_body(ModeChunked, LenMostNeg);
    queue_item("A", 1'b0);
    queue_close();
    start_body(ModeChunked, '0);
    queue_close();

    // Receiver holds off for a long stretch while the sender keeps going.
    start_body(ModeClose, LenUnlimited);
    in_gap_max = 0;
    out_gap_max = 0;
    stall_arm = 1'b1;
    repeat (80) queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
    queue_close();
    drain();
    stall_arm = 1'b0;

    // Random bodies, mostly chunked.
    while (n_sent - n_tail < 1250) begin
      case ($urandom_range(0, 9))
        0: begin
          start_body(ModeNone, LenRegW'({$urandom, $urandom}));
          queue_tail();
        end
        1, 2, 3: begin
          plain_len = 0;
          case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = LenUnlimited;
            2:       len = LenMax;
            3:       len = LenMostNeg;
            4:       len = LenRegW'(-int'($urandom_range(2, 1000)));
            default: begin
              plain_len = $urandom_range(1, 40);
              len = LenRegW'(plain_len);
            end
          endcase
          if ($urandom_range(0, 2) == 0) begin
            // Until close, possibly with a byte limit.
            start_body(ModeClose, len);
            repeat ($urandom_range(1, 40)) queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
            queue_close();
          end else begin
            start_body(ModeLength, len);
            if (plain_len > 0) begin
              if ($urandom_range(0, 3) == 0) n = $urandom_range(0, plain_len - 1);
              else n = plain_len;
              repeat (n) queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
              if (n < plain_len) queue_close();
            end else if (len != '0) begin
              repeat ($urandom_range(20, 40)) queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
              queue_close();
            end
          end
          queue_tail();
        end
        default: begin
          start_body(ModeChunked, LenRegW'({$urandom, $urandom}));
          case ($urandom_range(0, 9))
            6: begin
              // Well-formed body cut off by a close at a random point.
              s0 = conn_q.size();
              queue_chunked_body();
              cut = $urandom_range(s0, conn_q.size() - 1);
              while (conn_q.size() > cut) begin
                void'(conn_q.pop_back());
                n_sent--;
              end
              queue_close();
            end
            7: begin
              // Size line or chunk-end line that never ends.
              if ($urandom_range(0, 1)) begin
                queue_item("1", 1'b0);
              end else begin
                queue_size_line(2);
                repeat (2) queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
              end
              repeat (130) queue_item(text_byte(), 1'b0);
            end
            8: begin
              // Size too large for the counter: it saturates.
              digits = "0123456789abcdefABCDEF";
              queue_item($urandom_range(0, 1) ? "f" : "F", 1'b0);
              repeat ($urandom_range(10, 15)) queue_item(digits[$urandom_range(0, 21)], 1'b0);
              queue_eol();
              repeat ($urandom_range(1, 20)) queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
              queue_close();
            end
            9: begin
              if ($urandom_range(0, 1)) begin
                // Size line with no hex digit reads as the last chunk.
                queue_text("zz");
                queue_eol();
                queue_eol();
              end else begin
                // Raw noise with the odd close.
                repeat ($urandom_range(10, 40)) begin
                  if ($urandom_range(0, 19) == 0) queue_close();
                  else queue_item(ByteW'($urandom_range(0, 255)), 1'b0);
                end
                queue_close();
              end
            end
            default: queue_chunked_body();
          endcase
          queue_tail();
        end
      endcase
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (deframed_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", deframed_q.size()));
    $display("Sent %0d requests over %0d bodies (%0d chunked) with %0d register writes.",
             n_sent, n_bodies, n_chunked, n_cfg);
    $display("Checked %0d results; input held back %0d cycles; %0d mismatches.",
             n_out, n_held, n_err);
    if (n_err == 0) begin
      $display("tb_http_body_chunked_deframer: done, clean");
    end else begin
      $display("tb_http_body_chunked_deframer: done, errors");
    end
    $finish;
  end

endmodule
